/* rtl/ifhg_pkg.sv */
// Shared types and constants for the IPv4 fragment header generator.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package ifhg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [12:0] UNITS_MIN   = 13'd128;
    localparam logic [12:0] UNITS_MAX   = 13'd8189;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_ADDRESS     = 3'd0,
        REG_DST_ADDRESS     = 3'd1,
        REG_DATAGRAM_ID     = 3'd2,
        REG_FRAGMENT_UNITS  = 3'd3,
        REG_TIME_TO_LIVE    = 3'd4,
        REG_PROTOCOL_NUMBER = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] datagram_id;
        logic [12:0] fragment_units;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
    } cfg_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] chunk;
        logic        more;
    } frag_t;

endpackage

/* rtl/ifhg_cfg.sv */
// Configuration register file of the fragment header generator.
// Depends on ifhg_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module ifhg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ifhg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ifhg_pkg::cfg_t                 cfg
);
    import ifhg_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_address     <= 32'hC0A8_0101;
            cfg_reg.dst_address     <= 32'hC0A8_0102;
            cfg_reg.datagram_id     <= 16'd54321;
            cfg_reg.fragment_units  <= 13'd1125;
            cfg_reg.time_to_live    <= 8'd64;
            cfg_reg.protocol_number <= 8'd17;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_ADDRESS:     cfg_reg.src_address     <= cfg_data;
                REG_DST_ADDRESS:     cfg_reg.dst_address     <= cfg_data;
                REG_DATAGRAM_ID:     cfg_reg.datagram_id     <= cfg_data[15:0];
                REG_FRAGMENT_UNITS:  cfg_reg.fragment_units  <= cfg_data[12:0];
                REG_TIME_TO_LIVE:    cfg_reg.time_to_live    <= cfg_data[7:0];
                REG_PROTOCOL_NUMBER: cfg_reg.protocol_number <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/ifhg_frag_gen.sv */
// Fragment sequencer: walks one datagram and issues one chunk per cycle while frag_ready is high.
// Depends on ifhg_pkg for cfg_t, frag_t and the chunk size limits.
`timescale 1ns / 1ps

module ifhg_frag_gen (
    input  logic           clk,
    input  logic           rst_n,
    input  ifhg_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [15:0]    datagram_length,
    output logic           frag_valid,
    input  logic           frag_ready,
    output ifhg_pkg::frag_t frag
);
    import ifhg_pkg::*;

    logic        active_reg;
    logic        active_next;
    logic [15:0] len_reg;
    logic [15:0] start_reg;
    logic [15:0] size_reg;
    logic [15:0] rest;
    logic        more;
    logic        issue;
    logic        accept;
    logic [12:0] units;
    logic [16:0] start_sum;

    always_comb
    begin
        units = cfg.fragment_units;
        if (units < UNITS_MIN)
        begin
            units = UNITS_MIN;
        end
        if (units > UNITS_MAX)
        begin
            units = UNITS_MAX;
        end
    end

    assign rest      = len_reg - start_reg;
    assign more      = rest > size_reg;
    assign start_sum = {1'b0, start_reg} + {1'b0, size_reg};

    assign frag_valid = active_reg;
    assign frag.start = start_reg;
    assign frag.chunk = more ? size_reg : rest;
    assign frag.more  = more;

    assign issue    = active_reg && frag_ready;
    assign in_stall = active_reg && !(frag_ready && !more);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        active_next = active_reg;
        if (issue && !more)
        begin
            active_next = 1'b0;
        end
        if (accept)
        begin
            active_next = (datagram_length != 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg   <= datagram_length;
            start_reg <= 16'd0;
            size_reg  <= {units, 3'b000};
        end
        else if (issue && more)
        begin
            start_reg <= start_sum[15:0];
        end
    end

endmodule

/* rtl/ifhg_csum_pipe.sv */
// Header field and checksum pipeline: sum, fold, complement, output register.
// Depends on ifhg_pkg for cfg_t, frag_t and the fixed header words.
`timescale 1ns / 1ps

module ifhg_csum_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  ifhg_pkg::cfg_t  cfg,
    input  logic            frag_valid,
    output logic            frag_ready,
    input  ifhg_pkg::frag_t frag,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [15:0]     total_length,
    output logic [12:0]     fragment_offset,
    output logic            mf_flag,
    output logic [15:0]     header_checksum,
    output logic [15:0]     payload_start,
    output logic [15:0]     chunk_length,
    output logic            last
);
    import ifhg_pkg::*;

    logic        s1_valid_reg;
    logic [15:0] s1_tot_reg;
    logic        s1_more_reg;
    logic [15:0] s1_start_reg;
    logic [15:0] s1_chunk_reg;
    logic [16:0] s1_sum_a_reg;
    logic [18:0] s1_sum_c_reg;

    logic        s2_valid_reg;
    logic [15:0] s2_tot_reg;
    logic        s2_more_reg;
    logic [15:0] s2_start_reg;
    logic [15:0] s2_chunk_reg;
    logic [16:0] s2_fold_reg;

    logic        s3_valid_reg;
    logic [15:0] s3_tot_reg;
    logic        s3_more_reg;
    logic [15:0] s3_start_reg;
    logic [15:0] s3_chunk_reg;
    logic [15:0] s3_csum_reg;

    logic        rdy1;
    logic        rdy2;
    logic        rdy3;
    logic [15:0] tot_next;
    logic [15:0] flags_off;
    logic [16:0] sum_a_next;
    logic [18:0] sum_c_next;
    logic [19:0] sum_all;
    logic [16:0] fold_next;
    logic [15:0] fold2;

    assign rdy3       = !s3_valid_reg || !out_stall;
    assign rdy2       = !s2_valid_reg || rdy3;
    assign rdy1       = !s1_valid_reg || rdy2;
    assign frag_ready = rdy1;

    assign tot_next   = HDR_BYTES + frag.chunk;
    assign flags_off  = {2'b00, frag.more, frag.start[15:3]};
    assign sum_a_next = {1'b0, tot_next} + {1'b0, flags_off};
    assign sum_c_next = {3'b000, VER_IHL_TOS}
                      + {3'b000, cfg.datagram_id}
                      + {3'b000, cfg.time_to_live, cfg.protocol_number}
                      + {3'b000, cfg.src_address[31:16]}
                      + {3'b000, cfg.src_address[15:0]}
                      + {3'b000, cfg.dst_address[31:16]}
                      + {3'b000, cfg.dst_address[15:0]};

    assign sum_all   = {3'b000, s1_sum_a_reg} + {1'b0, s1_sum_c_reg};
    assign fold_next = {13'd0, sum_all[19:16]} + {1'b0, sum_all[15:0]};
    assign fold2     = s2_fold_reg[15:0] + {15'd0, s2_fold_reg[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= frag_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && frag_valid)
        begin
            s1_tot_reg   <= tot_next;
            s1_more_reg  <= frag.more;
            s1_start_reg <= frag.start;
            s1_chunk_reg <= frag.chunk;
            s1_sum_a_reg <= sum_a_next;
            s1_sum_c_reg <= sum_c_next;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_tot_reg   <= s1_tot_reg;
            s2_more_reg  <= s1_more_reg;
            s2_start_reg <= s1_start_reg;
            s2_chunk_reg <= s1_chunk_reg;
            s2_fold_reg  <= fold_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_tot_reg   <= s2_tot_reg;
            s3_more_reg  <= s2_more_reg;
            s3_start_reg <= s2_start_reg;
            s3_chunk_reg <= s2_chunk_reg;
            s3_csum_reg  <= ~fold2;
        end
    end

    assign out_valid       = s3_valid_reg;
    assign total_length    = s3_tot_reg;
    assign fragment_offset = s3_start_reg[15:3];
    assign mf_flag         = s3_more_reg;
    assign header_checksum = s3_csum_reg;
    assign payload_start   = s3_start_reg;
    assign chunk_length    = s3_chunk_reg;
    assign last            = !s3_more_reg;

endmodule

/* rtl/ipv4_fragment_header_generator.sv */
// IPv4 fragment header generator, top level.
// A datagram's first header passes the sequencer registers, then stages s1, s2, s3;
// one header per cycle after that while out_stall stays low.
// The input stalls while the fragments (1..64) of a datagram are issued, and is free
// as the last one goes; ifhg_frag_gen issues one per cycle while frag_ready is high.
// Reset: rst_n clears all valid state and loads the register defaults.
// Depends on ifhg_pkg, ifhg_cfg, ifhg_frag_gen and ifhg_csum_pipe.
`timescale 1ns / 1ps

module ipv4_fragment_header_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ifhg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [15:0]                      datagram_length,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [15:0]                      total_length,
    output logic [12:0]                      fragment_offset,
    output logic                             mf_flag,
    output logic [15:0]                      header_checksum,
    output logic [15:0]                      payload_start,
    output logic [15:0]                      chunk_length,
    output logic                             last
);
    import ifhg_pkg::*;

    cfg_t  cfg;
    frag_t frag;
    logic  frag_valid;
    logic  frag_ready;

    ifhg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifhg_frag_gen u_frag_gen (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .datagram_length (datagram_length),
        .frag_valid      (frag_valid),
        .frag_ready      (frag_ready),
        .frag            (frag)
    );

    ifhg_csum_pipe u_csum_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .frag_valid      (frag_valid),
        .frag_ready      (frag_ready),
        .frag            (frag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .total_length    (total_length),
        .fragment_offset (fragment_offset),
        .mf_flag         (mf_flag),
        .header_checksum (header_checksum),
        .payload_start   (payload_start),
        .chunk_length    (chunk_length),
        .last            (last)
    );

    a_idle_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !frag_valid |-> !in_stall)
        else $error("input stalled while sequencer idle");

    a_total_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_length == chunk_length + 16'd20))
        else $error("total length does not match chunk length");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last != mf_flag))
        else $error("last and more-fragments flags disagree");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fragment_offset == payload_start[15:3]))
        else $error("fragment offset does not match payload start");

endmodule

/* tb/ipv4_fragment_header_checker.sv */
// Scoreboard for the IPv4 fragment header generator: mirrors register writes,
// predicts the fragment headers of each accepted datagram and compares every output item.
// Depends on ifhg_pkg.
`timescale 1ns / 1ps

module ipv4_fragment_header_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ifhg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ifhg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [15:0]                      datagram_length,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [15:0]                      total_length,
    input  logic [12:0]                      fragment_offset,
    input  logic                             mf_flag,
    input  logic [15:0]                      header_checksum,
    input  logic [15:0]                      payload_start,
    input  logic [15:0]                      chunk_length,
    input  logic                             last,
    output int                               mismatches,
    output int                               outstanding,
    output int                               headers_checked
);

    import ifhg_pkg::*;

    localparam logic [31:0] SRC_RESET      = 32'hC0A8_0101;
    localparam logic [31:0] DST_RESET      = 32'hC0A8_0102;
    localparam logic [15:0] ID_RESET       = 16'd54321;
    localparam logic [12:0] UNITS_RESET    = 13'd1125;
    localparam logic [7:0]  TTL_RESET      = 8'd64;
    localparam logic [7:0]  PROTO_RESET    = 8'd17;
    localparam logic [15:0] MF_FLAG        = 16'h2000;
    localparam int          MAX_FRAGMENTS  = 64;

    typedef struct packed {
        logic [15:0] total_length;
        logic [12:0] fragment_offset;
        logic        mf_flag;
        logic [15:0] header_checksum;
        logic [15:0] payload_start;
        logic [15:0] chunk_length;
        logic        last;
    } frag_header_t;

    cfg_t         regs;
    frag_header_t expected_headers[$];
    int           fail_tally;
    int           seen_tally;

    function automatic logic [15:0] header_checksum_of(input logic [15:0] tot,
                                                       input logic [15:0] flags_off);
        logic [31:0] sum;
        sum = 32'(VER_IHL_TOS) + 32'(tot) + 32'(regs.datagram_id) + 32'(flags_off)
            + 32'({regs.time_to_live, regs.protocol_number})
            + 32'(regs.src_address[31:16]) + 32'(regs.src_address[15:0])
            + 32'(regs.dst_address[31:16]) + 32'(regs.dst_address[15:0]);
        sum = 32'(sum[31:16]) + 32'(sum[15:0]);
        sum = sum + (sum >> 16);
        return ~sum[15:0];
    endfunction

    function automatic void plan_fragments(input logic [15:0] len);
        int unsigned  units;
        int unsigned  size;
        int unsigned  start;
        int unsigned  chunk;
        int           count;
        frag_header_t hdr;
        logic [15:0]  flags_off;
        units = regs.fragment_units;
        if (units < UNITS_MIN)
            units = UNITS_MIN;
        if (units > UNITS_MAX)
            units = UNITS_MAX;
        size  = units * 8;
        start = 0;
        count = 0;
        while (start < len && count < MAX_FRAGMENTS)
        begin
            chunk = (len - start < size) ? len - start : size;
            hdr.mf_flag         = (start + size < len);
            hdr.fragment_offset = 13'(start / 8);
            hdr.total_length    = 16'(HDR_BYTES + chunk);
            hdr.payload_start   = 16'(start);
            hdr.chunk_length    = 16'(chunk);
            hdr.last            = !hdr.mf_flag;
            flags_off = {3'b000, hdr.fragment_offset} | (hdr.mf_flag ? MF_FLAG : 16'h0000);
            hdr.header_checksum = header_checksum_of(hdr.total_length, flags_off);
            expected_headers.insert(expected_headers.size(), hdr);
            start += size;
            count++;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frag_header_t want;
        if (!rst_n)
        begin
            regs.src_address     = SRC_RESET;
            regs.dst_address     = DST_RESET;
            regs.datagram_id     = ID_RESET;
            regs.fragment_units  = UNITS_RESET;
            regs.time_to_live    = TTL_RESET;
            regs.protocol_number = PROTO_RESET;
            expected_headers.delete();
            fail_tally = 0;
            seen_tally = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_tally++;
                if (expected_headers.size() == 0)
                begin
                    $display("%0t: header with nothing expected, expected none, %s 0x%0h 0x%0h",
                             $time, "actual offset and length", fragment_offset, total_length);
                    fail_tally++;
                end
                else
                begin
                    want = expected_headers[0];
                    expected_headers.delete(0);
                    check_field("total_length",    want.total_length,    total_length);
                    check_field("fragment_offset", want.fragment_offset, fragment_offset);
                    check_field("mf_flag",         want.mf_flag,         mf_flag);
                    check_field("header_checksum", want.header_checksum, header_checksum);
                    check_field("payload_start",   want.payload_start,   payload_start);
                    check_field("chunk_length",    want.chunk_length,    chunk_length);
                    check_field("last",            want.last,            last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SRC_ADDRESS:     regs.src_address     = cfg_data;
                    REG_DST_ADDRESS:     regs.dst_address     = cfg_data;
                    REG_DATAGRAM_ID:     regs.datagram_id     = cfg_data[15:0];
                    REG_FRAGMENT_UNITS:  regs.fragment_units  = cfg_data[12:0];
                    REG_TIME_TO_LIVE:    regs.time_to_live    = cfg_data[7:0];
                    REG_PROTOCOL_NUMBER: regs.protocol_number = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                plan_fragments(datagram_length);
        end
        mismatches      <= fail_tally;
        outstanding     <= expected_headers.size();
        headers_checked <= seen_tally;
    end

endmodule

/* tb/tb_ipv4_fragment_header_generator.sv */
// Top of the fragment header generator testbench: clock, reset, register writes,
// datagram stimulus with idle and stall bursts, and the verdict.
// Depends on ifhg_pkg, ipv4_fragment_header_generator and ipv4_fragment_header_checker.
`timescale 1ns / 1ps

module tb_ipv4_fragment_header_generator;

    import ifhg_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ROUNDS = 6;
    localparam int ROUND_ITEMS   = 50;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            datagram_length;
    logic                   out_valid;
    logic                   out_stall;
    logic [15:0]            total_length;
    logic [12:0]            fragment_offset;
    logic                   mf_flag;
    logic [15:0]            header_checksum;
    logic [15:0]            payload_start;
    logic [15:0]            chunk_length;
    logic                   last;

    int mismatches;
    int outstanding;
    int headers_checked;
    int cycles;
    int datagrams_sent;
    int settings_used;
    int unsigned chunk_bytes;
    bit tx_gaps;
    bit rx_gaps;
    bit hold_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ipv4_fragment_header_generator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .datagram_length (datagram_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .total_length    (total_length),
        .fragment_offset (fragment_offset),
        .mf_flag         (mf_flag),
        .header_checksum (header_checksum),
        .payload_start   (payload_start),
        .chunk_length    (chunk_length),
        .last            (last)
    );

    ipv4_fragment_header_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .datagram_length (datagram_length),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .total_length    (total_length),
        .fragment_offset (fragment_offset),
        .mf_flag         (mf_flag),
        .header_checksum (header_checksum),
        .payload_start   (payload_start),
        .chunk_length    (chunk_length),
        .last            (last),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .headers_checked (headers_checked)
    );

    // receiver: random stall bursts, or one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0)
            begin
                if (hold_req)
                begin
                    hold_left = LONG_HOLD;
                    hold_req  = 1'b0;
                end
                else if (rx_gaps && $urandom_range(0, 5) == 0)
                    hold_left = $urandom_range(1, 12);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_config(input logic [31:0] src, input logic [31:0] dst,
                                input logic [31:0] id_word, input logic [31:0] units_word,
                                input logic [31:0] ttl_word, input logic [31:0] proto_word);
        int unsigned units;
        write_reg(REG_SRC_ADDRESS, src);
        write_reg(REG_DST_ADDRESS, dst);
        write_reg(REG_DATAGRAM_ID, id_word);
        write_reg(REG_FRAGMENT_UNITS, units_word);
        write_reg(REG_TIME_TO_LIVE, ttl_word);
        write_reg(REG_PROTOCOL_NUMBER, proto_word);
        cfg_valid <= 1'b0;
        units = units_word[12:0];
        if (units < UNITS_MIN)
            units = UNITS_MIN;
        if (units > UNITS_MAX)
            units = UNITS_MAX;
        chunk_bytes = units * 8;
        settings_used++;
    endtask

    task automatic random_config();
        int unsigned units;
        logic [31:0] units_word;
        case ($urandom_range(0, 9))
            0:       units = $urandom_range(0, 127);
            1:       units = $urandom_range(8190, 8191);
            2, 3:    units = $urandom_range(4000, 8189);
            default: units = $urandom_range(128, 1500);
        endcase
        units_word = $urandom;
        units_word[12:0] = units[12:0];
        write_config($urandom, $urandom, $urandom, units_word, $urandom, $urandom);
    endtask

    task automatic send_datagram(input logic [15:0] len);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid        <= 1'b0;
            datagram_length <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        datagram_length <= len;
        do
            @(posedge clk);
        while (in_stall);
        datagrams_sent++;
    endtask

    // drop valid, then hold until every predicted header has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_length();
        int unsigned k;
        int unsigned v;
        case ($urandom_range(0, 19))
            0:           v = 0;
            1, 2, 3, 4, 5, 6, 7:
                         v = $urandom_range(1, 2048);
            8, 9, 10, 11:
                         v = $urandom_range(1, 65535);
            12:          v = $urandom_range(65532, 65535);
            13, 14, 15, 16:
            begin
                k = $urandom_range(1, 65535 / chunk_bytes);
                v = k * chunk_bytes + $urandom_range(0, 2);
                v = v - 1;
                if (v > 65535)
                    v = 65535;
            end
            default:
            begin
                v = (chunk_bytes > 65535) ? 65535 : chunk_bytes;
                v = $urandom_range(1, v);
            end
        endcase
        return v[15:0];
    endfunction

    initial
    begin
        int round;
        int i;
        rst_n = 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_SRC_ADDRESS;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        datagram_length <= '0;
        datagrams_sent = 0;
        settings_used  = 1;
        chunk_bytes    = 9000;
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b1;
        hold_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: 9000-byte chunks
        send_datagram(16'd1);
        send_datagram(16'd8);
        send_datagram(16'd9000);
        send_datagram(16'd9001);
        send_datagram(16'd18000);
        send_datagram(16'd0);
        send_datagram(16'd65535);
        wait_drained();

        // all registers zero, chunk size clamps up to 1024 bytes
        write_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_datagram(16'd65535);
        send_datagram(16'd1024);
        send_datagram(16'd1025);
        send_datagram(16'd2048);
        wait_drained();

        // all bits set, chunk size clamps down to 65512 bytes
        write_config('1, '1, '1, '1, '1, '1);
        send_datagram(16'd65512);
        send_datagram(16'd65513);
        send_datagram(16'd65535);
        send_datagram(16'd1);
        wait_drained();

        write_config(32'h0A00_0001, 32'h0A00_0002, 32'h1234, 32'd127, 32'd128, 32'd6);
        send_datagram(16'd65535);
        wait_drained();
        write_config(32'h8000_0000, 32'h0000_0001, 32'h8000, 32'd8190, 32'd1, 32'd128);
        send_datagram(16'd65535);
        wait_drained();
        write_config(32'h5555_AAAA, 32'hAAAA_5555, 32'h00FF, 32'd8189, 32'd255, 32'd17);
        send_datagram(16'd65513);
        wait_drained();

        // unused register indexes must leave the settings alone
        write_config(32'h7F00_0001, 32'hFFFF_0000, 32'hFF00, 32'd128, 32'd64, 32'd1);
        @(posedge clk);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        send_datagram(16'd65535);
        send_datagram(16'd1023);
        wait_drained();

        for (round = 0; round < RANDOM_ROUNDS; round++)
        begin
            random_config();
            if (round == RANDOM_ROUNDS - 1)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            else if (round == 1)
            begin
                tx_gaps  = 1'b0;
                rx_gaps  = 1'b1;
                hold_req = 1'b1;
            end
            else
            begin
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
            end
            for (i = 0; i < ROUND_ITEMS; i++)
            begin
                if (i == ROUND_ITEMS / 2)
                    wait_drained();
                send_datagram(pick_length());
            end
            wait_drained();
        end

        $display("Sent %0d datagrams, checked %0d fragment headers over %0d register settings,",
                 datagrams_sent, headers_checked, settings_used);
        $display("with idle gaps, stall bursts and a long output hold.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
